[src/dsl_pkg.sv]
// Package: constants, types and helpers for the differencing/smoothing/lag feature stream
package dsl_pkg;
  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned DIFF_MAX_DEF = 8;
  localparam int unsigned WIN_MAX_DEF  = 16;
  localparam int unsigned LAG_MAX_DEF  = 8;

  localparam int unsigned CH_W     = 4;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SUM_W    = 37;
  localparam int unsigned RECIP_W  = 17;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAG   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_WRITE,
    ST_EMIT
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W+RECIP_W:0] v);
    logic signed [SUM_W+RECIP_W:0] hi;
    logic signed [SUM_W+RECIP_W:0] lo;
    hi = (SUM_W+RECIP_W+1)'(signed'(32'sh7fffffff));
    lo = (SUM_W+RECIP_W+1)'(signed'(32'sh80000000));
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[VAL_W-1:0];
  endfunction
endpackage

[src/dsl_mem.sv]
// Single-port-write, single-port-read synchronous memory with a registered read
module dsl_mem import dsl_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/diff_smooth_lag_feature_stream.sv]
// Top level: per-channel differencing, moving mean and lag-window feature stream
//
// Samples arrive tagged with a channel; each channel keeps its own raw, difference
// and mean histories in three synchronous memories and its running sum, count and
// ring pointer in small register files. A sample is processed one at a time, in
// order: take it, read the memories, form difference and sum, do the reciprocal
// multiply, write back, then make lag_depth+1 result transfers, newest mean first.
// Each result takes a mean read, the load of the output register and the transfer
// itself, which waits while out_stall is high. During warm-up an item produces no
// results and ends at the write back; in_stall stays high until the item has ended.
// Mean history is shifted by rewriting rather than moving: entries are addressed
// as a ring per channel. A batch start clears the channel's count and running sum.
// Registers take effect at once; write them only while the block is idle.
// Channels at or above CHANNELS are dropped. Out-of-range register values are
// clamped. No clearing pass: histories are only read once written.
module diff_smooth_lag_feature_stream import dsl_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned DIFF_MAX = DIFF_MAX_DEF,
  parameter int unsigned WIN_MAX  = WIN_MAX_DEF,
  parameter int unsigned LAG_MAX  = LAG_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CH_W-1:0]          in_channel,
  input  logic signed [VAL_W-1:0]  in_sample_value,
  input  logic                     in_batch_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_out_channel,
  output logic [3:0]               out_lag_position,
  output logic signed [VAL_W-1:0]  out_feature_value,
  output logic                     out_last_of_window
);
  localparam int unsigned CAP    = DIFF_MAX + WIN_MAX + LAG_MAX + 1;
  localparam int unsigned CNT_W  = $clog2(CAP + 1);
  localparam int unsigned CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DPW    = (DIFF_MAX > 1) ? $clog2(DIFF_MAX) : 1;
  localparam int unsigned WPW    = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int unsigned LD     = LAG_MAX + 1;
  localparam int unsigned LPW    = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned RAW_D  = CHANNELS * DIFF_MAX;
  localparam int unsigned DIF_D  = CHANNELS * WIN_MAX;
  localparam int unsigned SM_D   = CHANNELS * LD;
  localparam int unsigned PROD_W = SUM_W + RECIP_W + 1;

  // configuration
  logic [3:0]         diff_r;
  logic [4:0]         win_r;
  logic [RECIP_W-1:0] recip_r;
  logic [3:0]         lag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r  <= 4'd1;
      win_r   <= 5'd1;
      recip_r <= 17'h10000;
      lag_r   <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIFF:  diff_r  <= cfg_data[3:0];
        REG_WIN:   win_r   <= cfg_data[4:0];
        REG_RECIP: recip_r <= cfg_data[RECIP_W-1:0];
        REG_LAG:   lag_r   <= cfg_data[3:0];
        default:   ;
      endcase
    end
  end

  // clamped values, wide enough for any parameter
  logic [7:0] d_c, w_c, l_c;
  always_comb begin
    d_c = (diff_r == 4'd0) ? 8'd1 : 8'(diff_r);
    if (32'(d_c) > DIFF_MAX) d_c = 8'(DIFF_MAX);
    w_c = (win_r == 5'd0) ? 8'd1 : 8'(win_r);
    if (32'(w_c) > WIN_MAX) w_c = 8'(WIN_MAX);
    l_c = 8'(lag_r);
    if (32'(l_c) > LAG_MAX) l_c = 8'(LAG_MAX);
  end

  // per-channel small state
  logic signed [SUM_W-1:0] sum_r  [CHANNELS];
  logic [CNT_W-1:0]        cnt_r  [CHANNELS];
  logic [WPW-1:0]          ring_r [CHANNELS];
  logic [DPW-1:0]          rawp_r [CHANNELS];
  logic [LPW-1:0]          smp_r  [CHANNELS];

  state_t state_r, state_nxt;

  logic [CHI_W-1:0]        ch_r;
  logic signed [VAL_W-1:0] x_r;
  logic [CNT_W-1:0]        c_r;
  logic signed [SUM_W-1:0] osum_r;
  logic [WPW-1:0]          pos_r;
  logic [DPW-1:0]          rp_r;
  logic [LPW-1:0]          sp_r;
  logic signed [VAL_W-1:0] diff_val_r;
  logic signed [SUM_W-1:0] nsum_r;
  logic                    do_diff_r, do_mean_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [3:0]              k_r;
  logic                    emit_r;

  // memories
  logic                    raw_we, dif_we, sm_we;
  logic [$clog2(RAW_D)-1:0] raw_wa, raw_ra;
  logic [$clog2(DIF_D)-1:0] dif_wa, dif_ra;
  logic [$clog2(SM_D)-1:0]  sm_wa, sm_ra;
  logic [VAL_W-1:0]        raw_rd, dif_rd, sm_rd, sm_wd;

  dsl_mem #(.DEPTH(RAW_D), .WIDTH(VAL_W)) u_raw (
    .clk, .we(raw_we), .waddr(raw_wa), .wdata(x_r), .raddr(raw_ra), .rdata(raw_rd));
  dsl_mem #(.DEPTH(DIF_D), .WIDTH(VAL_W)) u_dif (
    .clk, .we(dif_we), .waddr(dif_wa), .wdata(diff_val_r), .raddr(dif_ra), .rdata(dif_rd));
  dsl_mem #(.DEPTH(SM_D), .WIDTH(VAL_W)) u_sm (
    .clk, .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(sm_ra), .rdata(sm_rd));

  // ring index helpers: raw slot d back, difference slot w back, mean slot k back
  // (the mean pointer has already moved past the newest entry when reading)
  logic [DPW-1:0] raw_old;
  logic [WPW-1:0] dif_old;
  logic [LPW-1:0] sm_k;
  logic [LPW-1:0] sp_inc;
  logic [31:0]    raw_idx, dif_idx, sm_idx;
  always_comb begin
    raw_idx = 32'(rp_r) + DIFF_MAX - 32'(d_c);
    if (raw_idx >= DIFF_MAX) raw_idx = raw_idx - DIFF_MAX;
    dif_idx = 32'(pos_r) + WIN_MAX - 32'(w_c);
    if (dif_idx >= WIN_MAX) dif_idx = dif_idx - WIN_MAX;
    sm_idx  = 32'(sp_r) + LD - 1 - 32'(k_r);
    if (sm_idx >= LD) sm_idx = sm_idx - LD;
    raw_old = DPW'(raw_idx);
    dif_old = WPW'(dif_idx);
    sm_k    = LPW'(sm_idx);
    sp_inc  = (32'(sp_r) == LD - 1) ? '0 : sp_r + 1'b1;
  end

  assign raw_ra = $bits(raw_ra)'(32'(ch_r) * DIFF_MAX + 32'(raw_old));
  assign dif_ra = $bits(dif_ra)'(32'(ch_r) * WIN_MAX + 32'(dif_old));
  assign sm_ra  = $bits(sm_ra)'(32'(ch_r) * LD + 32'(sm_k));
  assign raw_wa = $bits(raw_wa)'(32'(ch_r) * DIFF_MAX + 32'(rp_r));
  assign dif_wa = $bits(dif_wa)'(32'(ch_r) * WIN_MAX + 32'(pos_r));
  assign sm_wa  = $bits(sm_wa)'(32'(ch_r) * LD + 32'(sp_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && 32'(in_channel) < CHANNELS) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = emit_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_valid && !out_stall && k_r == 4'(l_c)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer; mean is round half up then saturated
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    raw_we   = (state_r == ST_WRITE);
    dif_we   = (state_r == ST_WRITE) && do_diff_r;
    sm_we    = (state_r == ST_WRITE) && do_mean_r;
    sm_wd    = sat32((prod_r + PROD_W'(32768)) >>> 16);
  end

  logic [CNT_W-1:0] cbase, cinc;
  always_comb begin
    cbase = in_batch_start ? '0 : cnt_r[CHI_W'(in_channel)];
    cinc  = (32'(cbase) >= CAP) ? CNT_W'(CAP) : cbase + 1'b1;
  end

  // output register, loaded from the mean memory one read ahead
  logic sm_rvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      sm_rvalid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        ring_r[i] <= '0;
        rawp_r[i] <= '0;
        smp_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && 32'(in_channel) < CHANNELS) begin
            ch_r   <= CHI_W'(in_channel);
            x_r    <= in_sample_value;
            c_r    <= cinc;
            osum_r <= in_batch_start ? '0 : sum_r[CHI_W'(in_channel)];
            pos_r  <= ring_r[CHI_W'(in_channel)];
            rp_r   <= rawp_r[CHI_W'(in_channel)];
            sp_r   <= smp_r[CHI_W'(in_channel)];
            cnt_r[CHI_W'(in_channel)] <= cinc;
            if (in_batch_start) sum_r[CHI_W'(in_channel)] <= '0;
          end
        end
        ST_READ: ;
        ST_CALC: begin
          logic signed [VAL_W:0] dd;
          logic signed [VAL_W-1:0] dsat;
          logic signed [SUM_W-1:0] s;
          logic [CNT_W-1:0] m;
          dd = $signed({x_r[VAL_W-1], x_r}) - $signed({raw_rd[VAL_W-1], raw_rd});
          if (dd > 33'sh07fffffff) dsat = 32'sh7fffffff;
          else if (dd < -33'sh080000000) dsat = 32'sh80000000;
          else dsat = dd[VAL_W-1:0];
          diff_val_r <= dsat;
          do_diff_r <= (32'(c_r) > 32'(d_c));
          m = c_r - CNT_W'(d_c);
          s = osum_r + SUM_W'(dsat);
          if (32'(m) > 32'(w_c)) s = s - SUM_W'(signed'(dif_rd));
          nsum_r    <= s;
          do_mean_r <= (32'(c_r) > 32'(d_c)) && (32'(m) >= 32'(w_c));
          emit_r    <= (32'(c_r) >= 32'(d_c) + 32'(w_c) + 32'(l_c));
        end
        ST_MUL: begin
          prod_r <= PROD_W'(nsum_r) * signed'({1'b0, recip_r});
          if (do_diff_r) begin
            sum_r[ch_r]  <= nsum_r;
            ring_r[ch_r] <= (32'(pos_r) == WIN_MAX - 1) ? '0 : pos_r + 1'b1;
          end
        end
        ST_WRITE: begin
          rawp_r[ch_r] <= (32'(rp_r) == DIFF_MAX - 1) ? '0 : rp_r + 1'b1;
          if (do_mean_r) begin
            smp_r[ch_r] <= sp_inc;
            sp_r        <= sp_inc;
          end
          k_r <= 4'd0;
          sm_rvalid_r <= 1'b0;
        end
        ST_EMIT: begin
          // mean read issued with k_r, data arrives next cycle
          if (!out_valid && !sm_rvalid_r) begin
            sm_rvalid_r <= 1'b1;
          end else if (sm_rvalid_r && !out_valid) begin
            out_valid          <= 1'b1;
            out_out_channel    <= CH_W'(ch_r);
            out_lag_position   <= k_r;
            out_feature_value  <= sm_rd;
            out_last_of_window <= (k_r == 4'(l_c));
            sm_rvalid_r        <= 1'b0;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            k_r       <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // wr of slot sp_r happens in ST_WRITE with the pointer before increment; mean
  // read for k uses the incremented pointer, so newest sits one back
endmodule

[verif/diff_smooth_lag_feature_stream_tb.sv]
// Self-checking testbench for the per-channel differencing, smoothing and lag feature stream
module diff_smooth_lag_feature_stream_tb import dsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH = CHANNELS_DEF;
  localparam int unsigned DMX = DIFF_MAX_DEF;
  localparam int unsigned WMX = WIN_MAX_DEF;
  localparam int unsigned LMX = LAG_MAX_DEF;
  localparam int unsigned COUNT_TOP = DMX + WMX + LMX + 1;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] sample;
    logic                    batch_start;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [3:0]              lag_pos;
    logic signed [VAL_W-1:0] feature;
    logic                    last;
  } feature_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CH_W-1:0] in_channel = '0;
  logic signed [VAL_W-1:0] in_sample_value = '0;
  logic in_batch_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_out_channel;
  logic [3:0] out_lag_position;
  logic signed [VAL_W-1:0] out_feature_value;
  logic out_last_of_window;

  diff_smooth_lag_feature_stream u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the block
  logic [3:0]  sh_diff;
  logic [4:0]  sh_win;
  logic [16:0] sh_recip;
  logic [3:0]  sh_lag;
  logic signed [VAL_W-1:0] raw_hist [NCH][DMX];
  logic signed [VAL_W-1:0] diff_ring [NCH][WMX];
  logic signed [SUM_W-1:0] win_sum [NCH];
  logic signed [VAL_W-1:0] mean_hist [NCH][LMX+1];
  int unsigned seen [NCH];
  int unsigned ring_wr [NCH];

  sample_t  pending_samples[$];
  feature_t expected_features[$];
  int errors = 0;
  int mismatches = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  function automatic logic signed [VAL_W-1:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // mean = floor((sum*recip + 2^15) / 2^16), saturated
  function automatic logic signed [VAL_W-1:0] scaled_mean(input logic signed [SUM_W-1:0] s,
                                                          input logic [16:0] r);
    logic signed [63:0] p;
    p = 64'(s) * $signed({1'b0, r}) + 64'sd32768;
    return clip32(p >>> 16);
  endfunction

  task automatic predict_features(input sample_t it);
    int unsigned d, w, l, c, m, pos, old;
    logic signed [VAL_W-1:0] dv;
    logic signed [SUM_W-1:0] s;
    feature_t f;
    d = (sh_diff < 1) ? 1 : (sh_diff > DMX) ? DMX : sh_diff;
    w = (sh_win < 1) ? 1 : (sh_win > WMX) ? WMX : sh_win;
    l = (sh_lag > LMX) ? LMX : sh_lag;
    if (it.channel >= NCH) return;
    if (it.batch_start) begin
      seen[it.channel] = 0;
      win_sum[it.channel] = '0;
    end
    c = seen[it.channel] + 1;
    if (c > COUNT_TOP) c = COUNT_TOP;
    seen[it.channel] = c;
    if (c > d) begin
      dv = clip32(64'(it.sample) - 64'(raw_hist[it.channel][d-1]));
      m = c - d;
      pos = ring_wr[it.channel] % WMX;
      old = (pos + WMX - w) % WMX;
      s = win_sum[it.channel] + SUM_W'(dv);
      if (m > w) s = s - SUM_W'(diff_ring[it.channel][old]);
      win_sum[it.channel] = s;
      diff_ring[it.channel][pos] = dv;
      ring_wr[it.channel] = (pos + 1) % WMX;
      if (m >= w) begin
        for (int i = LMX; i > 0; i--) mean_hist[it.channel][i] = mean_hist[it.channel][i-1];
        mean_hist[it.channel][0] = scaled_mean(s, sh_recip);
      end
    end
    for (int i = DMX - 1; i > 0; i--) raw_hist[it.channel][i] = raw_hist[it.channel][i-1];
    raw_hist[it.channel][0] = it.sample;
    if (c >= d + w + l) begin
      for (int k = 0; k <= l; k++) begin
        f.channel = it.channel;
        f.lag_pos = 4'(k);
        f.feature = mean_hist[it.channel][k];
        f.last = (k == l);
        expected_features = {expected_features, f};
      end
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sender: one transfer per accepted beat, new item chosen after the edge
  int in_gap = 0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_features({in_channel, in_sample_value, in_batch_start});
      in_gap = gap_len();
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0 || pending_samples.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        sample_t it;
        it = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_channel <= it.channel;
        in_sample_value <= it.sample;
        in_batch_start <= it.batch_start;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt = 400;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 0;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_gap = gap_len();
      out_stall <= (out_gap > 0);
    end
  end

  // monitor and comparison
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_features.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected transfer ch=%0d lag=%0d val=%0d",
                                        out_out_channel, out_lag_position, out_feature_value);
      end else begin
        feature_t e;
        e = expected_features.pop_front();
        if (e.channel !== out_out_channel || e.lag_pos !== out_lag_position ||
            e.feature !== out_feature_value || e.last !== out_last_of_window) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch exp ch=%0d lag=%0d val=%0d last=%0b ",
                      "got ch=%0d lag=%0d val=%0d last=%0b"},
                     e.channel, e.lag_pos, e.feature, e.last, out_out_channel,
                     out_lag_position, out_feature_value, out_last_of_window);
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DIFF:  sh_diff = 4'(v);
      REG_WIN:   sh_win = 5'(v);
      REG_RECIP: sh_recip = 17'(v);
      default:   sh_lag = 4'(v);
    endcase
  endtask

  task automatic set_regs(input int unsigned d, w, r, l);
    write_reg(REG_DIFF, d);
    write_reg(REG_WIN, w);
    write_reg(REG_RECIP, r);
    write_reg(REG_LAG, l);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_features.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 2000)) - 32'sd1000);
      default: return $signed($urandom());
    endcase
  endfunction

  // batch of well-formed sequences: a batch start per channel then a run of samples
  task automatic queue_batch(input int n, input bit fresh);
    sample_t it;
    bit started [NCH];
    for (int i = 0; i < NCH; i++) started[i] = !fresh;
    for (int i = 0; i < n; i++) begin
      it.channel = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
      it.sample = rand_sample();
      it.batch_start = !started[it.channel] || ($urandom_range(0, 40) == 0);
      started[it.channel] = 1;
      pending_samples = {pending_samples, it};
    end
  endtask

  initial begin
    sample_t it;
    sh_diff = 1; sh_win = 1; sh_recip = 17'd65536; sh_lag = 0;
    for (int c = 0; c < NCH; c++) begin
      seen[c] = 0; ring_wr[c] = 0; win_sum[c] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of every field at reset settings, then extreme settings
    set_regs(1, 1, 65536, 0);
    for (int i = 0; i < 8; i++) begin
      it.channel = 4'(i == 0 ? 0 : 15);
      it.batch_start = (i < 2);
      it.sample = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      pending_samples = {pending_samples, it};
    end
    wait_drained();
    // maximal windows and lags, out-of-range clamps, zero reciprocal
    set_regs(15, 31, 0, 15);
    queue_batch(15, 1);
    wait_drained();
    set_regs(0, 0, 1, 0);
    queue_batch(10, 1);
    wait_drained();

    // random phases through several settings, lag maximal to force back-pressure
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned w;
      w = (ph == 1) ? 16 : $urandom_range(1, 5);
      set_regs($urandom_range(1, 8), w, (ph == 4) ? 131071 : 65536 / w,
               (ph == 2) ? 8 : $urandom_range(0, 3));
      if (ph == 2) hold_req = 1;
      queue_batch(ph == 1 ? 70 : 45, 1);
      wait_drained();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[filelist.f]
src/dsl_pkg.sv
src/dsl_mem.sv
src/diff_smooth_lag_feature_stream.sv
verif/diff_smooth_lag_feature_stream_tb.sv
